>>> rtl/crrt_pkg.sv
//------------------------------------------------------------------------------
// crrt_pkg
// Shared types, sizes and the spline basis function of the ribbon tessellator.
//------------------------------------------------------------------------------
`default_nettype none

package crrt_pkg;

    localparam int COORD_W        = 32;
    localparam int VNUM_W         = 13;
    localparam int COUNT_W        = 9;
    localparam int COUNT_CAP      = 511;
    localparam int SAMPLES_DEF    = 10;
    localparam int MAX_POINTS_DEF = 256;

    typedef logic signed [COORD_W-1:0] coord_t;

    // Top level sequencer.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PLAN,
        ST_START,
        ST_WAIT,
        ST_PUSH,
        ST_UPDATE
    } crrt_seq_t;

    // Coordinate evaluator.
    typedef enum logic [2:0] {
        EV_IDLE,
        EV_MAC,
        EV_DIVA,
        EV_DIVB,
        EV_DONE
    } crrt_ev_t;

    // Uniform Catmull-Rom basis weight of control point k at t = j/s, scaled by 2*s^3.
    function automatic int cr_weight(int k, int j, int s);
        int j2;
        int j3;
        int w;
        j2 = j * j;
        j3 = j2 * j;
        case (k)
            0:       w = -j3 + 2 * j2 * s - j * s * s;
            1:       w = 3 * j3 - 5 * j2 * s + 2 * s * s * s;
            2:       w = -3 * j3 + 4 * j2 * s + j * s * s;
            default: w = j3 - j2 * s;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> rtl/catmull_rom_ribbon_tessellator.sv
//------------------------------------------------------------------------------
// catmull_rom_ribbon_tessellator
// Control pairs (lower and upper rail points) come in one beat each; every pair
// from the third on releases one uniform Catmull-Rom segment, and the final pair
// of a trail releases the closing segment as well, with the end points
// duplicated. Each segment gives SAMPLES_PER_SEGMENT samples, each a lower and
// then an upper vertex beat carrying a running vertex number; run_end marks the
// last vertex beat caused by a pair. One pair is worked at a time. All
// coordinates go through one evaluator built around a single 33x33 multiplier,
// which works each coordinate in four multiply-accumulate steps and then the
// digit steps of the divide, between a start and a finish; any stall on the
// result side holds the work of a pair. The next pair is taken while the last
// vertex beat still waits in the output register.
//------------------------------------------------------------------------------
`default_nettype none

module catmull_rom_ribbon_tessellator #(
    parameter int SAMPLES_PER_SEGMENT = crrt_pkg::SAMPLES_DEF,
    parameter int MAX_POINTS          = crrt_pkg::MAX_POINTS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic signed [31:0]           s_under_x,
    input  wire logic signed [31:0]           s_under_y,
    input  wire logic signed [31:0]           s_under_z,
    input  wire logic signed [31:0]           s_upper_x,
    input  wire logic signed [31:0]           s_upper_y,
    input  wire logic signed [31:0]           s_upper_z,
    input  wire logic                         s_final_point,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic signed [31:0]                m_pos_x,
    output logic signed [31:0]                m_pos_y,
    output logic signed [31:0]                m_pos_z,
    output logic                              m_rail_sel,
    output logic [crrt_pkg::VNUM_W-1:0]       m_vertex_number,
    output logic                              m_run_end
);

    localparam int JW = $clog2(SAMPLES_PER_SEGMENT);
    localparam int VW = crrt_pkg::VNUM_W;
    localparam int NW = crrt_pkg::COUNT_W;
    localparam logic [VW-1:0] VLIMIT = VW'((MAX_POINTS - 1) * 2 * SAMPLES_PER_SEGMENT);
    localparam logic [JW-1:0] J_LAST = JW'(SAMPLES_PER_SEGMENT - 1);

    crrt_pkg::crrt_seq_t state_reg, state_next;

    logic [NW-1:0]    seen_reg;
    logic [VW-1:0]    vcount_reg;
    logic             last_reg;
    logic             seg_b_reg;
    logic             seg_b_en_reg;
    logic [JW-1:0]    j_reg;
    logic             rail_reg;
    logic [1:0]       axis_reg;
    logic             m_valid_reg;

    // Window entry 0 is the newest stored point; [rail][axis] below it.
    crrt_pkg::coord_t win_reg   [3][2][3];
    crrt_pkg::coord_t cur_reg   [2][3];
    crrt_pkg::coord_t coord_reg [3];

    crrt_pkg::coord_t ev_pts [4];
    crrt_pkg::coord_t ev_result;
    crrt_pkg::coord_t w0, w1, w2, cp;
    logic             ev_start;
    logic             ev_done;

    logic has_a;
    logic has_b;
    logic no_work;
    logic out_free;
    logic out_load;
    logic final_pos;
    logic vtx_end;

    assign has_a    = (seen_reg >= NW'(2));
    assign has_b    = last_reg && (seen_reg != '0);
    assign no_work  = !(has_a || has_b) || (vcount_reg >= VLIMIT);
    assign out_free = !m_valid_reg || m_ready;
    assign final_pos = (j_reg == J_LAST) && rail_reg && (seg_b_reg || !seg_b_en_reg);
    assign vtx_end  = final_pos || ((vcount_reg + VW'(1)) == VLIMIT);

    // Point set of the current segment; short trails fold onto their end points.
    always_comb begin
        w0 = win_reg[0][rail_reg][axis_reg];
        w1 = win_reg[1][rail_reg][axis_reg];
        w2 = win_reg[2][rail_reg][axis_reg];
        cp = cur_reg[rail_reg][axis_reg];
        if (seg_b_reg) begin
            ev_pts[0] = (seen_reg == NW'(1)) ? w0 : w1;
            ev_pts[1] = w0;
            ev_pts[2] = cp;
        end else begin
            ev_pts[0] = (seen_reg == NW'(2)) ? w1 : w2;
            ev_pts[1] = w1;
            ev_pts[2] = w0;
        end
        ev_pts[3] = cp;
    end

    crrt_eval #(
        .SAMPLES (SAMPLES_PER_SEGMENT)
    ) u_eval (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ev_start  (ev_start),
        .ev_j      (j_reg),
        .ev_pts    (ev_pts),
        .ev_done   (ev_done),
        .ev_result (ev_result)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            crrt_pkg::ST_IDLE:   if (s_valid) state_next = crrt_pkg::ST_PLAN;
            crrt_pkg::ST_PLAN:   state_next = no_work ? crrt_pkg::ST_UPDATE : crrt_pkg::ST_START;
            crrt_pkg::ST_START:  state_next = crrt_pkg::ST_WAIT;
            crrt_pkg::ST_WAIT: begin
                if (ev_done) begin
                    state_next = (axis_reg == 2'd2) ? crrt_pkg::ST_PUSH : crrt_pkg::ST_START;
                end
            end
            crrt_pkg::ST_PUSH: begin
                if (out_free) begin
                    state_next = vtx_end ? crrt_pkg::ST_UPDATE : crrt_pkg::ST_START;
                end
            end
            crrt_pkg::ST_UPDATE: state_next = crrt_pkg::ST_IDLE;
            default:             state_next = crrt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready  = (state_reg == crrt_pkg::ST_IDLE);
        ev_start = (state_reg == crrt_pkg::ST_START);
        out_load = (state_reg == crrt_pkg::ST_PUSH) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= crrt_pkg::ST_IDLE;
            seen_reg     <= '0;
            vcount_reg   <= '0;
            last_reg     <= 1'b0;
            seg_b_reg    <= 1'b0;
            seg_b_en_reg <= 1'b0;
            j_reg        <= '0;
            rail_reg     <= 1'b0;
            axis_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (s_valid && s_ready) begin
                last_reg <= s_final_point;
            end
            if (state_reg == crrt_pkg::ST_PLAN) begin
                seg_b_reg    <= !has_a;
                seg_b_en_reg <= has_b;
                j_reg        <= '0;
                rail_reg     <= 1'b0;
                axis_reg     <= '0;
            end
            if ((state_reg == crrt_pkg::ST_WAIT) && ev_done && (axis_reg != 2'd2)) begin
                axis_reg <= axis_reg + 2'd1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
                vcount_reg  <= vcount_reg + VW'(1);
                axis_reg    <= '0;
                rail_reg    <= !rail_reg;
                if (rail_reg) begin
                    if (j_reg == J_LAST) begin
                        j_reg     <= '0;
                        seg_b_reg <= 1'b1;
                    end else begin
                        j_reg <= j_reg + JW'(1);
                    end
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == crrt_pkg::ST_UPDATE) begin
                if (last_reg) begin
                    seen_reg   <= '0;
                    vcount_reg <= '0;
                end else if (seen_reg != NW'(crrt_pkg::COUNT_CAP)) begin
                    seen_reg <= seen_reg + NW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cur_reg[0][0] <= s_under_x;
            cur_reg[0][1] <= s_under_y;
            cur_reg[0][2] <= s_under_z;
            cur_reg[1][0] <= s_upper_x;
            cur_reg[1][1] <= s_upper_y;
            cur_reg[1][2] <= s_upper_z;
        end
        if ((state_reg == crrt_pkg::ST_WAIT) && ev_done) begin
            coord_reg[axis_reg] <= ev_result;
        end
        if (out_load) begin
            m_pos_x         <= coord_reg[0];
            m_pos_y         <= coord_reg[1];
            m_pos_z         <= coord_reg[2];
            m_rail_sel      <= rail_reg;
            m_vertex_number <= vcount_reg;
            m_run_end       <= vtx_end;
        end
        // A window that is not yet full is never read, so a trail end needs no clear.
        if ((state_reg == crrt_pkg::ST_UPDATE) && !last_reg) begin
            win_reg[2] <= win_reg[1];
            win_reg[1] <= win_reg[0];
            win_reg[0] <= cur_reg;
        end
    end

    assign m_valid = m_valid_reg;

    a_vnum_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_vertex_number < VLIMIT))
        else $error("vertex beat numbered at or beyond the vertex limit");

    a_vcount_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        vcount_reg <= VLIMIT)
        else $error("vertex counter ran past the vertex limit");

    a_lower_not_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_rail_sel) |-> !m_run_end)
        else $error("run end flagged on a lower rail vertex");

endmodule

`default_nettype wire

>>> rtl/crrt_eval.sv
//------------------------------------------------------------------------------
// crrt_eval
// Evaluates one spline coordinate with a single shared 33x33 multiplier: four
// multiply-accumulate steps, then an exact divide by 2*S^3 in 16-bit digits by
// reciprocal multiplication, rounding to nearest and saturating to 32 bits.
//------------------------------------------------------------------------------
`default_nettype none

module crrt_eval #(
    parameter int SAMPLES = crrt_pkg::SAMPLES_DEF,
    localparam int JW = $clog2(SAMPLES)
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            ev_start,
    input  wire logic [JW-1:0]   ev_j,
    input  wire crrt_pkg::coord_t ev_pts [4],
    output logic                 ev_done,
    output crrt_pkg::coord_t     ev_result
);

    localparam int D   = 2 * SAMPLES * SAMPLES * SAMPLES;
    localparam int L   = $clog2(D);
    localparam int WW  = L + 2;               // signed weight width
    localparam int XW  = L + 16;              // partial dividend: remainder and one digit
    localparam int MW  = XW + 1;              // reciprocal width
    localparam int P   = XW + L;              // reciprocal scale
    localparam int PW  = P + 16;
    localparam int NCH = (L + 35 + 15) / 16;  // digits in the accumulator
    localparam int AW  = NCH * 16;
    localparam int CW  = ($clog2(NCH) > 2) ? $clog2(NCH) : 2;

    localparam logic [63:0]   MREC     = ((64'd1 << P) + 64'(D) - 64'd1) / 64'(D);
    localparam logic [L:0]    DV       = (L + 1)'(D);
    localparam logic [AW-1:0] ACC_INIT = AW'(D / 2) + (AW'(D) << 32);
    localparam logic [AW-1:0] Q_LO     = AW'(64'd1 << 31);
    localparam logic [AW-1:0] Q_HI     = AW'(64'd3 << 31);

    crrt_pkg::crrt_ev_t state_reg, state_next;
    logic [CW-1:0]      cnt_reg;
    logic [AW-1:0]      acc_reg;
    logic [L-1:0]       rem_reg;
    logic [PW-1:0]      prod_reg;
    logic [AW-1:0]      quo_reg;

    logic signed [WW-1:0] wtab [4][SAMPLES];
    logic signed [WW-1:0] w_sel;
    logic [15:0]          chunk;
    logic [XW-1:0]        x_val;
    logic [XW-1:0]        rem_calc;
    logic [15:0]          digit;
    logic signed [32:0]   mul_a;
    logic signed [32:0]   mul_b;
    logic signed [65:0]   mul_p;
    logic                 mac_last;
    logic                 div_last;

    for (genvar gk = 0; gk < 4; gk++) begin : g_k
        for (genvar gj = 0; gj < SAMPLES; gj++) begin : g_j
            assign wtab[gk][gj] = WW'(crrt_pkg::cr_weight(gk, gj, SAMPLES));
        end
    end

    assign w_sel    = wtab[cnt_reg[1:0]][ev_j];
    assign chunk    = acc_reg[AW-1 -: 16];
    assign x_val    = {rem_reg, chunk};
    assign digit    = prod_reg[PW-1 -: 16];
    assign rem_calc = x_val - mul_p[XW-1:0];
    assign mac_last = (cnt_reg == CW'(3));
    assign div_last = (cnt_reg == CW'(NCH - 1));

    // The shared multiplier: weight times point, digit estimate, digit times divisor.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            crrt_pkg::EV_MAC: begin
                mul_a = 33'(w_sel);
                mul_b = 33'(ev_pts[cnt_reg[1:0]]);
            end
            crrt_pkg::EV_DIVA: begin
                mul_a = 33'(x_val);
                mul_b = 33'(MREC[MW-1:0]);
            end
            crrt_pkg::EV_DIVB: begin
                mul_a = 33'(digit);
                mul_b = 33'(DV);
            end
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            crrt_pkg::EV_IDLE: if (ev_start) state_next = crrt_pkg::EV_MAC;
            crrt_pkg::EV_MAC:  if (mac_last) state_next = crrt_pkg::EV_DIVA;
            crrt_pkg::EV_DIVA: state_next = crrt_pkg::EV_DIVB;
            crrt_pkg::EV_DIVB: state_next = div_last ? crrt_pkg::EV_DONE : crrt_pkg::EV_DIVA;
            crrt_pkg::EV_DONE: state_next = crrt_pkg::EV_IDLE;
            default:           state_next = crrt_pkg::EV_IDLE;
        endcase
    end

    // The accumulator starts with half the divisor for rounding plus 2^32
    // divisors, so the dividend is never negative; the bias comes back out of
    // the low 32 quotient bits for free.
    always_comb begin
        ev_done = (state_reg == crrt_pkg::EV_DONE);
        if (quo_reg < Q_LO) begin
            ev_result = 32'sh8000_0000;
        end else if (quo_reg >= Q_HI) begin
            ev_result = 32'sh7fff_ffff;
        end else begin
            ev_result = quo_reg[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= crrt_pkg::EV_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                crrt_pkg::EV_IDLE: cnt_reg <= '0;
                crrt_pkg::EV_MAC:  cnt_reg <= mac_last ? '0 : cnt_reg + CW'(1);
                crrt_pkg::EV_DIVB: cnt_reg <= cnt_reg + CW'(1);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            crrt_pkg::EV_IDLE: begin
                acc_reg <= ACC_INIT;
                rem_reg <= '0;
            end
            crrt_pkg::EV_MAC:  acc_reg <= acc_reg + mul_p[AW-1:0];
            crrt_pkg::EV_DIVA: prod_reg <= mul_p[PW-1:0];
            crrt_pkg::EV_DIVB: begin
                rem_reg <= rem_calc[L-1:0];
                quo_reg <= {quo_reg[AW-17:0], digit};
                acc_reg <= acc_reg << 16;
            end
            default: ;
        endcase
    end

    a_done_single: assert property (@(posedge aclk) disable iff (!aresetn)
        ev_done |=> !ev_done)
        else $error("evaluator done held for more than one cycle");

    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == crrt_pkg::EV_DIVB) |=> ({1'b0, rem_reg} < DV))
        else $error("digit estimate left a remainder not below the divisor");

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ev_start |-> (state_reg == crrt_pkg::EV_IDLE))
        else $error("evaluator started while busy");

endmodule

`default_nettype wire
